FILE: rtl/shrp_pkg.sv
// shared constants, types and codes of the 3x3 rgb sharpen stream
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package shrp_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    localparam int NUM_CH = 3;
    localparam int CH_W   = 8;
    localparam int PIX_W  = NUM_CH * CH_W;

    localparam int LEVEL_W    = 7;
    localparam int FWIDTH_W   = 12;
    localparam int FHEIGHT_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // effective width must hold both the register and MAX_WIDTH itself
    localparam int EW_W = ($clog2(MAX_WIDTH + 1) > FWIDTH_W) ? $clog2(MAX_WIDTH + 1) : FWIDTH_W;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 7'd100;
    localparam logic [LEVEL_W-1:0]   LEVEL_RESET  = 7'd0;
    localparam logic [FWIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [FHEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [EW_W-1:0]      WIDTH_MIN    = EW_W'(3);
    localparam logic [EW_W-1:0]      WIDTH_MAX    = EW_W'(MAX_WIDTH);
    localparam logic [FHEIGHT_W-1:0] HEIGHT_MIN   = 16'd3;

    // floor(x/50) = (x*RECIP) >> 21 and floor(x/200) = (x*RECIP) >> 23 for x <= 25500
    localparam int              RECIP_W      = 16;
    localparam logic [RECIP_W-1:0] RECIP     = 16'd41944;
    localparam int              GAIN_W       = LEVEL_W + RECIP_W;
    localparam int              PROD_W       = CH_W + GAIN_W;
    localparam int              SHIFT_CENTER = 21;
    localparam int              SHIFT_NEIGH  = 23;
    localparam int              QC_W         = 9;
    localparam int              QN_W         = 7;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_t;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SHARP,
        KIND_FLUSH_A,
        KIND_FLUSH_B
    } kind_t;

endpackage

`default_nettype wire

FILE: rtl/sharpen_3x3_rgb_stream.sv
// top level of the 3x3 cross sharpen for an rgb pixel stream
// depends on shrp_pkg and shrp_ram
//
// usage:
//   s_ channel carries requests in raster order: s_tuser[0] low is a pixel,
//   high is a flush tick that drains one pending pixel once the whole frame
//   has arrived. m_ channel returns filtered pixels in raster order, m_tlast
//   on the last pixel of the frame. border rows and columns pass unchanged.
//   results trail the input by frame_width+1 pixels; the last frame_width+1
//   come out on flush requests. requests that cause no result are dropped.
//   throughput is one request per clock while s_tready is high; a result
//   passes ram read, window, multiply, sum and clamp and the output register
//   after the request that causes it is accepted. one ram of 2048 x 48 bits holds
//   the two previous rows, read and rewritten once per pixel on separate ports.
//   a stalled receiver fills the output register and a skid register, then
//   s_tready drops; nothing is lost or repeated.
//   reset (aresetn low, synchronous) sets level 0, width 640, height 480 and
//   restarts the frame; writing width or height also restarts the frame.
//   configuration is written through cfg_wr_en / cfg_index / cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none

module sharpen_3x3_rgb_stream (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [shrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [shrp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [23:0]                         s_tdata,  // in_red, in_green, in_blue
    input  wire logic [0:0]                          s_tuser,  // action
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [23:0]                         m_tdata,  // out_red, out_green, out_blue
    output logic                                     m_tlast
);

    import shrp_pkg::*;

    // configuration
    logic [LEVEL_W-1:0]   level_reg;
    logic [FWIDTH_W-1:0]  width_reg;
    logic [FHEIGHT_W-1:0] height_reg;
    logic [GAIN_W-1:0]    gain_reg;

    logic [LEVEL_W-1:0]   level_eff;
    logic [EW_W-1:0]      width_ext;
    logic [EW_W-1:0]      width_eff;
    logic [EW_W-1:0]      width_last;
    logic [FHEIGHT_W-1:0] height_eff;
    logic [FHEIGHT_W-1:0] height_last;
    logic                 restart_cfg;

    // position counters
    col_t                 in_col_reg;
    logic [FHEIGHT_W-1:0] in_row_reg;
    col_t                 out_col_reg;
    logic [FHEIGHT_W-1:0] out_row_reg;

    // request decode
    logic  adv;
    logic  accept;
    logic  in_done;
    logic  take_pixel;
    logic  take_flush;
    logic  pix_emit;
    logic  emit;
    logic  emit_last;
    kind_t kind;
    col_t  rd_addr;

    // stage 1: ram read
    logic  s1_valid_reg;
    logic  s1_pixel_reg;
    kind_t s1_kind_reg;
    logic  s1_last_reg;
    logic  s1_fwd_reg;
    col_t  s1_addr_reg;
    pix_t  s1_pix_reg;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] ram_wdata;
    logic [2*PIX_W-1:0] fwd_word_reg;
    logic [2*PIX_W-1:0] rd_word;
    logic               ram_we;
    pix_t               rd_a;
    pix_t               rd_b;

    // window columns still needed
    pix_t w02_reg;
    pix_t w12_reg;
    pix_t w22_reg;
    pix_t w11_reg;

    // stage 2: operands
    logic s2_valid_reg;
    logic s2_last_reg;
    logic s2_sharp_reg;
    pix_t s2_pass_reg;
    pix_t s2_ctr_reg;
    pix_t s2_up_reg;
    pix_t s2_dn_reg;
    pix_t s2_lf_reg;
    pix_t s2_rt_reg;

    // stage 3: quotients
    logic            s3_valid_reg;
    logic            s3_last_reg;
    logic            s3_sharp_reg;
    pix_t            s3_pass_reg;
    pix_t            s3_ctr_reg;
    logic [QC_W-1:0] s3_qc_reg [NUM_CH];
    logic [QN_W-1:0] s3_qu_reg [NUM_CH];
    logic [QN_W-1:0] s3_qd_reg [NUM_CH];
    logic [QN_W-1:0] s3_ql_reg [NUM_CH];
    logic [QN_W-1:0] s3_qr_reg [NUM_CH];

    logic [QC_W-1:0] qc [NUM_CH];
    logic [QN_W-1:0] qu [NUM_CH];
    logic [QN_W-1:0] qd [NUM_CH];
    logic [QN_W-1:0] ql [NUM_CH];
    logic [QN_W-1:0] qr [NUM_CH];

    pix_t sharp_word;
    pix_t out_word;

    // output register and skid
    logic m_valid_reg;
    pix_t m_data_reg;
    logic m_last_reg;
    logic skid_valid_reg;
    pix_t skid_data_reg;
    logic skid_last_reg;

    // ---------------------------------------------------------------- config
    always_comb begin
        level_eff  = (level_reg > LEVEL_MAX) ? LEVEL_MAX : level_reg;
        width_ext  = EW_W'(width_reg);
        if (width_ext < WIDTH_MIN) begin
            width_eff = WIDTH_MIN;
        end else if (width_ext > WIDTH_MAX) begin
            width_eff = WIDTH_MAX;
        end else begin
            width_eff = width_ext;
        end
        width_last  = width_eff - EW_W'(1);
        height_eff  = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
        height_last = height_eff - FHEIGHT_W'(1);
        restart_cfg = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= LEVEL_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LEVEL:  level_reg  <= cfg_data[LEVEL_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[FWIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[FHEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // level times reciprocal, shared by all lanes
    always_ff @(posedge aclk) begin
        gain_reg <= GAIN_W'(level_eff) * GAIN_W'(RECIP);
    end

    // ---------------------------------------------------------------- decode
    always_comb begin
        adv        = !skid_valid_reg;
        accept     = s_tvalid && adv;
        in_done    = in_row_reg >= height_eff;
        take_pixel = accept && !s_tuser[0] && !in_done;
        take_flush = accept && s_tuser[0] && in_done;

        // first row and the first pixel of the second row give nothing
        pix_emit = !(in_row_reg == '0 || (in_row_reg == FHEIGHT_W'(1) && in_col_reg == '0));
        emit     = (take_pixel && pix_emit) || take_flush;

        if (take_flush) begin
            kind = (out_row_reg >= height_last) ? KIND_FLUSH_A : KIND_FLUSH_B;
        end else if (in_row_reg >= FHEIGHT_W'(2) && in_col_reg >= COL_W'(2)) begin
            kind = KIND_SHARP;
        end else begin
            kind = KIND_PASS;
        end

        emit_last = (out_row_reg == height_last) && (EW_W'(out_col_reg) == width_last);
        rd_addr   = s_tuser[0] ? out_col_reg : in_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart_cfg || (emit && emit_last)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (take_pixel) begin
                if (EW_W'(in_col_reg) == width_last) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + FHEIGHT_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (emit) begin
                if (EW_W'(out_col_reg) == width_last) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + FHEIGHT_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_pixel_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= emit;
            s1_pixel_reg <= take_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_kind_reg <= kind;
            s1_last_reg <= emit_last;
            // the word written at this edge is not yet visible on the read port
            s1_fwd_reg  <= s1_pixel_reg && (s1_addr_reg == rd_addr);
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= s_tdata;
        end
    end

    always_comb begin
        rd_word   = s1_fwd_reg ? fwd_word_reg : ram_rdata;
        rd_a      = rd_word[PIX_W-1:0];
        rd_b      = rd_word[2*PIX_W-1:PIX_W];
        ram_we    = adv && s1_pixel_reg;
        ram_wdata = {rd_a, s1_pix_reg};
    end

    // upper half: row two back, lower half: previous row
    shrp_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_word_reg <= ram_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w02_reg <= '0;
            w12_reg <= '0;
            w22_reg <= '0;
            w11_reg <= '0;
        end else if (adv && s1_pixel_reg) begin
            w11_reg <= w12_reg;
            w02_reg <= rd_b;
            w12_reg <= rd_a;
            w22_reg <= s1_pix_reg;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_last_reg  <= s1_last_reg;
            s2_sharp_reg <= (s1_kind_reg == KIND_SHARP);
            case (s1_kind_reg)
                KIND_FLUSH_A: s2_pass_reg <= rd_a;
                KIND_FLUSH_B: s2_pass_reg <= rd_b;
                default:      s2_pass_reg <= w12_reg;
            endcase
            s2_ctr_reg <= w12_reg;
            s2_up_reg  <= w02_reg;
            s2_dn_reg  <= w22_reg;
            s2_lf_reg  <= w11_reg;
            s2_rt_reg  <= rd_a;
        end
    end

    // ---------------------------------------------------------------- stage 3
    function automatic logic [PROD_W-1:0] scale(input logic [CH_W-1:0] v,
                                                input logic [GAIN_W-1:0] g);
        scale = PROD_W'(v) * PROD_W'(g);
    endfunction

    always_comb begin
        logic [PROD_W-1:0] pc;
        logic [PROD_W-1:0] pu;
        logic [PROD_W-1:0] pd;
        logic [PROD_W-1:0] pl;
        logic [PROD_W-1:0] pr;
        for (int ln = 0; ln < NUM_CH; ln++) begin
            pc = scale(s2_ctr_reg[ln*CH_W +: CH_W], gain_reg);
            pu = scale(s2_up_reg[ln*CH_W +: CH_W], gain_reg);
            pd = scale(s2_dn_reg[ln*CH_W +: CH_W], gain_reg);
            pl = scale(s2_lf_reg[ln*CH_W +: CH_W], gain_reg);
            pr = scale(s2_rt_reg[ln*CH_W +: CH_W], gain_reg);
            qc[ln] = pc[SHIFT_CENTER +: QC_W];
            qu[ln] = pu[SHIFT_NEIGH +: QN_W];
            qd[ln] = pd[SHIFT_NEIGH +: QN_W];
            ql[ln] = pl[SHIFT_NEIGH +: QN_W];
            qr[ln] = pr[SHIFT_NEIGH +: QN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_last_reg  <= s2_last_reg;
            s3_sharp_reg <= s2_sharp_reg;
            s3_pass_reg  <= s2_pass_reg;
            s3_ctr_reg   <= s2_ctr_reg;
            for (int ln = 0; ln < NUM_CH; ln++) begin
                s3_qc_reg[ln] <= qc[ln];
                s3_qu_reg[ln] <= qu[ln];
                s3_qd_reg[ln] <= qd[ln];
                s3_ql_reg[ln] <= ql[ln];
                s3_qr_reg[ln] <= qr[ln];
            end
        end
    end

    // sum and clamp to 0..255
    always_comb begin
        logic [CH_W+1:0] pos;
        logic [QN_W+1:0] neg;
        logic [CH_W+1:0] diff;
        for (int ln = 0; ln < NUM_CH; ln++) begin
            pos  = (CH_W + 2)'(s3_ctr_reg[ln*CH_W +: CH_W]) + (CH_W + 2)'(s3_qc_reg[ln]);
            neg  = (QN_W + 2)'(s3_qu_reg[ln]) + (QN_W + 2)'(s3_qd_reg[ln])
                 + (QN_W + 2)'(s3_ql_reg[ln]) + (QN_W + 2)'(s3_qr_reg[ln]);
            diff = pos - (CH_W + 2)'(neg);
            if ((CH_W + 2)'(neg) > pos) begin
                sharp_word[ln*CH_W +: CH_W] = '0;
            end else if (diff[CH_W+1:CH_W] != 2'b00) begin
                sharp_word[ln*CH_W +: CH_W] = '1;
            end else begin
                sharp_word[ln*CH_W +: CH_W] = diff[CH_W-1:0];
            end
        end
        out_word = s3_sharp_reg ? sharp_word : s3_pass_reg;
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (s3_valid_reg) begin
            if (m_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
                m_last_reg <= skid_last_reg;
            end
        end else if (s3_valid_reg) begin
            if (m_valid_reg && !m_tready) begin
                skid_data_reg <= out_word;
                skid_last_reg <= s3_last_reg;
            end else begin
                m_data_reg <= out_word;
                m_last_reg <= s3_last_reg;
            end
        end
    end

    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: rtl/shrp_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module shrp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
